### rtl/utb_pkg.sv
// Shared types and constants for the UTF-8 to BMP code unit decoder.
package utb_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Low4Mask  = 8'h0F;
  localparam logic [7:0] Low5Mask  = 8'h1F;
  localparam logic [7:0] Low6Mask  = 8'h3F;

  localparam logic [15:0] BomFwd = 16'hFEFF;
  localparam logic [15:0] BomRev = 16'hFFFE;

  typedef struct packed {
    logic [1:0] pending_count;
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic       expect_three;
  } state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_char;
    logic [1:0]  unconsumed;
  } result_t;

  typedef result_t [MaxResults-1:0] bundle_t;

endpackage

### rtl/utb_if.sv
// Request channels of the decoder: input byte channel and result channel.
interface utb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface utb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_char;
  logic        last;
  logic [1:0]  unconsumed;

  modport source (output valid, output code_unit, output is_char, output last,
                  output unconsumed, input ready);
  modport sink (input valid, input code_unit, input is_char, input last,
                input unconsumed, output ready);
endinterface

### rtl/utb_decode.sv
// Decode step: one byte against the held sequence state, giving up to four results.
module utb_decode (
  input  utb_pkg::state_t  st,
  input  logic [7:0]       data_byte,
  input  logic             end_of_buffer,
  output utb_pkg::state_t  st_next,
  output utb_pkg::bundle_t res,
  output logic [2:0]       res_count
);

  logic        cont;
  logic        lead3;
  logic        lead2;
  logic        restart;
  logic [15:0] unit2;
  logic [15:0] unit3;
  logic [2:0]  n;

  assign cont  = (data_byte & utb_pkg::ContMask) == utb_pkg::ContCode;
  assign lead3 = (data_byte & utb_pkg::Lead3Mask) == utb_pkg::Lead3Code;
  assign lead2 = (data_byte & utb_pkg::Lead2Mask) == utb_pkg::Lead2Code;

  assign unit2 = {5'd0, st.lead_byte[4:0], data_byte[5:0]};
  assign unit3 = {st.lead_byte[3:0], st.second_byte[5:0], data_byte[5:0]};

  always_comb begin
    st_next = st;
    res     = '0;
    n       = '0;
    restart = 1'b0;

    if (st.pending_count == 2'd1 && st.expect_three) begin
      if (cont) begin
        st_next.second_byte   = data_byte;
        st_next.pending_count = 2'd2;
      end else begin
        res[n[1:0]] = '{code_unit: {8'd0, st.lead_byte}, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
        st_next.pending_count = 2'd0;
        restart = 1'b1;
      end
    end else if (st.pending_count == 2'd1) begin
      st_next.pending_count = 2'd0;
      if (cont) begin
        res[n[1:0]] = '{code_unit: unit2, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
      end else begin
        res[n[1:0]] = '{code_unit: {8'd0, st.lead_byte}, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
        restart = 1'b1;
      end
    end else if (st.pending_count == 2'd2) begin
      st_next.pending_count = 2'd0;
      if (cont) begin
        // drop byte-order marks
        if (unit3 != utb_pkg::BomFwd && unit3 != utb_pkg::BomRev) begin
          res[n[1:0]] = '{code_unit: unit3, is_char: 1'b1, unconsumed: 2'd0};
          n = n + 3'd1;
        end
      end else begin
        res[n[1:0]] = '{code_unit: {8'd0, st.lead_byte}, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
        res[n[1:0]] = '{code_unit: {8'd0, st.second_byte}, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
        restart = 1'b1;
      end
    end else begin
      st_next.pending_count = 2'd0;
      restart = 1'b1;
    end

    if (restart) begin
      if (lead3) begin
        st_next.pending_count = 2'd1;
        st_next.lead_byte     = data_byte;
        st_next.expect_three  = 1'b1;
      end else if (lead2) begin
        st_next.pending_count = 2'd1;
        st_next.lead_byte     = data_byte;
        st_next.expect_three  = 1'b0;
      end else begin
        res[n[1:0]] = '{code_unit: {8'd0, data_byte}, is_char: 1'b1, unconsumed: 2'd0};
        n = n + 3'd1;
      end
    end

    if (end_of_buffer) begin
      res[n[1:0]] = '{code_unit: 16'd0, is_char: 1'b0, unconsumed: st_next.pending_count};
      n = n + 3'd1;
      st_next = '0;
    end

    res_count = n;
  end

endmodule

### rtl/utf8_to_bmp_decoder.sv
// Top level of the streaming UTF-8 to 16-bit BMP code unit decoder.
//
// rx takes one source byte per request with an end_of_buffer flag; tx gives
// result requests: decoded code units, raw bytes of broken sequences, and an
// end marker (is_char 0) that reports the bytes of a truncated sequence.
// last marks the final result caused by one input byte.
//
// A byte is decoded in the cycle it is taken; its results are registered and
// appear on tx in the next cycle. An input byte that yields one result or none
// is taken every cycle while tx does not stall. A byte that yields up to four
// results holds the result register until they have all left, and the next
// byte is taken in the cycle its last result leaves, so throughput is set by
// the one-result-per-cycle output port, which tx stalls can hold.
//
// Reset clears the held sequence and empties the result register. When tx
// stalls, the current result holds and rx keeps ready low until the last
// result of the byte in the result register leaves.
module utf8_to_bmp_decoder (
  input  logic          clk,
  input  logic          rst,
  utb_in_if.sink        rx,
  utb_out_if.source     tx
);

  utb_pkg::state_t  st;
  utb_pkg::state_t  st_next;
  utb_pkg::bundle_t dec_res;
  logic [2:0]       dec_count;

  utb_pkg::bundle_t res;
  logic [2:0]       cnt;
  logic [1:0]       idx;
  logic             busy;

  logic accept;
  logic pop;
  logic final_pop;
  logic at_last;

  utb_decode u_decode (
    .st            (st),
    .data_byte     (rx.data_byte),
    .end_of_buffer (rx.end_of_buffer),
    .st_next       (st_next),
    .res           (dec_res),
    .res_count     (dec_count)
  );

  assign at_last   = {1'b0, idx} == (cnt - 3'd1);
  assign pop       = busy && tx.ready;
  assign final_pop = pop && at_last;
  assign rx.ready  = !busy || final_pop;
  assign accept    = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      busy <= 1'b0;
      idx  <= '0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept && dec_count != 3'd0) begin
        busy <= 1'b1;
        idx  <= '0;
        cnt  <= dec_count;
      end else if (final_pop) begin
        busy <= 1'b0;
      end else if (pop) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_count != 3'd0) begin
      res <= dec_res;
    end
  end

  assign tx.valid      = busy;
  assign tx.code_unit  = res[idx].code_unit;
  assign tx.is_char    = res[idx].is_char;
  assign tx.unconsumed = res[idx].unconsumed;
  assign tx.last       = at_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < cnt))
    else $error("result index beyond loaded count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !tx.ready) |=> (busy && $stable(idx)))
    else $error("result moved while receiver stalled");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !res[idx].is_char) |-> at_last)
    else $error("end marker is not the final result");

  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.end_of_buffer) |=> (st.pending_count == 2'd0))
    else $error("sequence state kept past end of buffer");

  a_pending_legal: assert property (@(posedge clk) disable iff (rst)
    st.pending_count != 2'd3)
    else $error("impossible pending count");

endmodule

### tb/utb_decode_monitor.sv
// Byte and result channel monitor for the decoder: predicts each result and checks it in order.
module utb_decode_monitor (
  input  logic clk,
  input  logic rst,
  utb_in_if    rx,
  utb_out_if   tx,
  output int   mismatches,
  output int   outstanding,
  output int   chars_checked,
  output int   markers_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] code_unit;
    logic        is_char;
    logic        last;
    logic [1:0]  unconsumed;
  } unit_rec_t;

  // Decoder state as seen from outside
  logic [1:0] held_cnt;
  logic [7:0] held_lead;
  logic [7:0] held_second;
  logic       want_three;

  unit_rec_t step_units[$];
  unit_rec_t due_units[$];
  unit_rec_t got_unit;
  unit_rec_t exp_unit;

  function automatic void clear_held();
    held_cnt    = '0;
    held_lead   = '0;
    held_second = '0;
    want_three  = 1'b0;
  endfunction

  function automatic void add_unit(logic [15:0] cu, logic ch, logic [1:0] unc);
    unit_rec_t r;
    r.code_unit  = cu;
    r.is_char    = ch;
    r.last       = 1'b0;
    r.unconsumed = unc;
    step_units.push_back(r);
  endfunction

  // No sequence open: hold a lead byte, pass anything else through raw.
  function automatic void start_unit(logic [7:0] b);
    if ((b & utb_pkg::Lead3Mask) == utb_pkg::Lead3Code) begin
      held_cnt   = 2'd1;
      held_lead  = b;
      want_three = 1'b1;
    end else if ((b & utb_pkg::Lead2Mask) == utb_pkg::Lead2Code) begin
      held_cnt   = 2'd1;
      held_lead  = b;
      want_three = 1'b0;
    end else begin
      add_unit({8'h00, b}, 1'b1, 2'd0);
    end
  endfunction

  function automatic void predict_units(logic [7:0] b, logic eob);
    logic        cont;
    logic [15:0] cu;
    step_units.delete();
    cont = (b & utb_pkg::ContMask) == utb_pkg::ContCode;
    case (held_cnt)
      2'd1: begin
        if (cont && want_three) begin
          held_second = b;
          held_cnt    = 2'd2;
        end else if (cont) begin
          cu = {5'd0, held_lead[4:0], b[5:0]};
          add_unit(cu, 1'b1, 2'd0);
          held_cnt = 2'd0;
        end else begin
          // broken sequence: flush the lead raw, then restart on this byte
          add_unit({8'h00, held_lead}, 1'b1, 2'd0);
          held_cnt = 2'd0;
          start_unit(b);
        end
      end
      2'd2: begin
        if (cont) begin
          cu = {held_lead[3:0], held_second[5:0], b[5:0]};
          if (cu != utb_pkg::BomFwd && cu != utb_pkg::BomRev) add_unit(cu, 1'b1, 2'd0);
          held_cnt = 2'd0;
        end else begin
          add_unit({8'h00, held_lead}, 1'b1, 2'd0);
          add_unit({8'h00, held_second}, 1'b1, 2'd0);
          held_cnt = 2'd0;
          start_unit(b);
        end
      end
      default: begin
        held_cnt = 2'd0;
        start_unit(b);
      end
    endcase
    if (eob) begin
      add_unit(16'h0000, 1'b0, held_cnt);
      clear_held();
    end
    if (step_units.size() > 0) step_units[step_units.size()-1].last = 1'b1;
    foreach (step_units[i]) due_units.push_back(step_units[i]);
  endfunction

  function automatic void report_bad(string what, unit_rec_t e, unit_rec_t g);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected unit %h char %b last %b unc %0d, ",
                "got unit %h char %b last %b unc %0d"},
               $time, what, e.code_unit, e.is_char, e.last, e.unconsumed,
               g.code_unit, g.is_char, g.last, g.unconsumed);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_held();
      due_units.delete();
    end else begin
      if (tx.valid && tx.ready) begin
        got_unit.code_unit  = tx.code_unit;
        got_unit.is_char    = tx.is_char;
        got_unit.last       = tx.last;
        got_unit.unconsumed = tx.unconsumed;
        if (got_unit.is_char === 1'b1) chars_checked++;
        else markers_checked++;
        if (due_units.size() == 0) begin
          exp_unit = '{default: '0};
          report_bad("result with none expected", exp_unit, got_unit);
        end else begin
          exp_unit = due_units.pop_front();
          if (got_unit.code_unit !== exp_unit.code_unit ||
              got_unit.is_char !== exp_unit.is_char ||
              got_unit.last !== exp_unit.last ||
              got_unit.unconsumed !== exp_unit.unconsumed)
            report_bad("result mismatch", exp_unit, got_unit);
        end
      end
      if (rx.valid && rx.ready) predict_units(rx.data_byte, rx.end_of_buffer);
    end
    outstanding = due_units.size();
  end

endmodule

### tb/tb_top.sv
// Top of the decoder regression: clock, reset, byte stimulus, result stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 430;
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 10;

  // Directed bytes, bit 8 flags end of buffer
  localparam logic [8:0] Directed [0:24] = '{
    9'h000, 9'h080, 9'h1FF,           // raw bytes, end marker with nothing held
    9'h0C2, 9'h0A9, 9'h0C1, 9'h0BF,   // two-byte sequence, overlong lead
    9'h0ED, 9'h0A0, 9'h080,           // surrogate value passes as is
    9'h0EF, 9'h0BB, 9'h0BF,           // byte-order mark, dropped
    9'h0EF, 9'h0BF, 9'h0BE,           // swapped byte-order mark, dropped
    9'h0E2, 9'h082, 9'h141,           // three-byte broken late: four results
    9'h0E2, 9'h041,                   // three-byte broken early
    9'h0C3, 9'h1E2,                   // two-byte broken by a lead, one byte left over
    9'h0E2, 9'h182                    // truncated three-byte, two bytes left over
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  int bytes_sent;
  int eobs_sent;
  int burst_left;
  int idle_cycles;
  bit long_hold_done;

  int mismatches;
  int outstanding;
  int chars_checked;
  int markers_checked;

  utb_in_if  byte_ch ();
  utb_out_if unit_ch ();

  utf8_to_bmp_decoder dut (
    .clk (clk),
    .rst (rst),
    .rx  (byte_ch),
    .tx  (unit_ch)
  );

  utb_decode_monitor mon (
    .clk             (clk),
    .rst             (rst),
    .rx              (byte_ch),
    .tx              (unit_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .chars_checked   (chars_checked),
    .markers_checked (markers_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one byte, idling a random gap (maybe none) when a burst has run out; returns
  // at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    if (eob) eobs_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return utb_pkg::ContCode | 8'($urandom_range(0, 63));
  endfunction

  // Any byte that is not a continuation byte
  function automatic logic [7:0] breaker_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ((b & utb_pkg::ContMask) == utb_pkg::ContCode) b = b | 8'h40;
    return b;
  endfunction

  // Mostly well-formed characters, with noise, broken and truncated sequences mixed in.
  task automatic send_random_unit();
    int   kind;
    logic eob;
    kind = $urandom_range(0, 99);
    eob  = ($urandom_range(0, 24) == 0);
    if (kind < 30) begin
      send_byte(8'($urandom_range(0, 127)), eob);
    end else if (kind < 50) begin
      send_byte(utb_pkg::Lead2Code | 8'($urandom_range(0, 31)), 1'b0);
      send_byte(cont_byte(), eob);
    end else if (kind < 75) begin
      send_byte(utb_pkg::Lead3Code | 8'($urandom_range(0, 15)), 1'b0);
      send_byte(cont_byte(), 1'b0);
      send_byte(cont_byte(), eob);
    end else if (kind < 78) begin
      send_byte(8'hEF, 1'b0);
      send_byte($urandom_range(0, 1) ? 8'hBB : 8'hBF, 1'b0);
      send_byte($urandom_range(0, 1) ? 8'hBF : 8'hBE, eob);
    end else if (kind < 88) begin
      send_byte(8'($urandom), eob);
    end else if (kind < 96) begin
      if ($urandom_range(0, 1)) begin
        send_byte(utb_pkg::Lead3Code | 8'($urandom_range(0, 15)), 1'b0);
        if ($urandom_range(0, 1)) send_byte(cont_byte(), 1'b0);
      end else begin
        send_byte(utb_pkg::Lead2Code | 8'($urandom_range(0, 31)), 1'b0);
      end
      send_byte(breaker_byte(), eob);
    end else begin
      // cut short by the end of the buffer
      if ($urandom_range(0, 1)) begin
        send_byte(utb_pkg::Lead3Code | 8'($urandom_range(0, 15)), 1'b0);
        send_byte(cont_byte(), 1'b1);
      end else begin
        send_byte(utb_pkg::Lead2Code | 8'($urandom_range(0, 31)), 1'b1);
      end
    end
  endtask

  // Result side: stall on its own pattern, and once hold off long enough to back up the input.
  initial begin
    int stall_mode;
    int span;
    unit_ch.ready <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span       = $urandom_range(8, 64);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (stall_mode)
          0: unit_ch.ready <= 1'b1;
          1: unit_ch.ready <= ($urandom_range(0, 1) == 1);
          2: unit_ch.ready <= ($urandom_range(0, 3) == 0);
          default: unit_ch.ready <= (i % 3 != 0);
        endcase
      end
      if (!long_hold_done && bytes_sent >= 150) begin
        @(negedge clk);
        unit_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        long_hold_done = 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("watchdog: no request moved for %0d cycles, %0d results still due",
               IdleLimit, outstanding);
      $display("utf8_to_bmp_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= 8'h00;
    byte_ch.end_of_buffer <= 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (Directed[i]) send_byte(Directed[i][7:0], Directed[i][8]);
    while (bytes_sent < ItemTarget) send_random_unit();
    byte_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("sent %0d bytes with %0d buffer ends; checked %0d characters and %0d end markers",
             bytes_sent, eobs_sent, chars_checked, markers_checked);
    $display("long result stall exercised: %0d, mismatches: %0d", long_hold_done, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("utf8_to_bmp_decoder regression: pass");
    end else begin
      $display("utf8_to_bmp_decoder regression: fail");
    end
    $finish;
  end

endmodule
